// File: design/waveform_linear_resampler_top_defines.svh
// Assertion macros shared by the resampler RTL.
// Define ASSERT_OFF to remove every assertion.
`ifndef WAVEFORM_LINEAR_RESAMPLER_TOP_DEFINES_SVH
`define WAVEFORM_LINEAR_RESAMPLER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: design/wlr_pkg.sv
// Package for the waveform linear resampler.
// Holds table sizes, mode codes and the controller state type; no dependencies.
package wlr_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_RD2,
        ST_RD3,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;
endpackage

// File: design/waveform_linear_resampler_top.sv
// Top level of the waveform linear resampler: table memories, pointer walk,
// iterative divider. Depends on wlr_pkg and waveform_linear_resampler_top_defines.svh.
//
//  channel  | ports                                   | handshake
//  request  | start, mode, sample_time, sample_value  | start && !busy
//  result   | done, interpolated_value, error_flag    | done for one cycle
//
// Clear, append and a query on fewer than two points finish without leaving idle.
// A query keeps busy high while it clamps the pointer, walks it segment by segment,
// reads both end points, multiplies and divides; the divider is skipped when the
// segment times are equal. The result comes in the first cycle with busy low. The
// divider is a 64-step restoring divider; the table memories give one read per cycle.
// Reset clears count, pointer and control; the memories need no clearing.
// The receiver cannot stall; busy holds off requests while a query runs.
`include "waveform_linear_resampler_top_defines.svh"
module waveform_linear_resampler_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [31:0]        sample_time,
    input  logic signed [31:0] sample_value,
    output logic               done,
    output logic signed [31:0] interpolated_value,
    output logic               error_flag
);
    localparam int IW = wlr_pkg::IDX_W;
    localparam int CW = wlr_pkg::CNT_W;

    logic [31:0] time_mem [wlr_pkg::MAX_POINTS];
    logic [31:0] val_mem  [wlr_pkg::MAX_POINTS];
    logic [31:0] rd_t, rd_v;
    logic [IW-1:0] rd_addr;
    logic wr_en;

    wlr_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] seg_reg, seg_next;
    logic [31:0] t_reg, t_next, x1_reg, x1_next;
    logic signed [31:0] y1_reg, y1_next;
    logic [31:0] mdy_reg, mdy_next, mdt_reg, mdt_next, mdx_reg, mdx_next;
    logic neg_reg, neg_next, eq_reg, eq_next;
    logic [63:0] prod_reg, prod_next, quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [5:0] bit_reg, bit_next;
    logic done_reg, done_next, err_reg, err_next;
    logic signed [31:0] res_reg, res_next;

    logic [CW-1:0] last;
    logic signed [33:0] dy, dt, dx;
    logic [32:0] rem_sh, rem_sub;
    logic signed [35:0] sum;

    assign last = count_reg - CW'(2);
    assign wr_en = (state_reg == wlr_pkg::ST_IDLE) && start && (mode == wlr_pkg::MODE_APPEND)
                   && (count_reg < CW'(wlr_pkg::MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[count_reg[IW-1:0]] <= sample_time;
            val_mem[count_reg[IW-1:0]]  <= sample_value;
        end
        rd_t <= time_mem[rd_addr];
        rd_v <= val_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wlr_pkg::ST_IDLE;
            count_reg <= '0;
            seg_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            seg_reg   <= seg_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next; x1_reg <= x1_next; y1_reg <= y1_next;
        mdy_reg <= mdy_next; mdt_reg <= mdt_next; mdx_reg <= mdx_next;
        neg_reg <= neg_next; eq_reg <= eq_next; prod_reg <= prod_next;
        quo_reg <= quo_next; rem_reg <= rem_next; bit_reg <= bit_next;
        err_reg <= err_next; res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg; count_next = count_reg; seg_next = seg_reg;
        t_next = t_reg; x1_next = x1_reg; y1_next = y1_reg;
        mdy_next = mdy_reg; mdt_next = mdt_reg; mdx_next = mdx_reg;
        neg_next = neg_reg; eq_next = eq_reg; prod_next = prod_reg;
        quo_next = quo_reg; rem_next = rem_reg; bit_next = bit_reg;
        err_next = err_reg; res_next = res_reg; done_next = 1'b0;
        rd_addr = seg_reg + IW'(1);
        dy = 34'($signed(rd_v)) - 34'(y1_reg);
        dt = $signed({2'b00, t_reg}) - $signed({2'b00, x1_reg});
        dx = $signed({2'b00, rd_t}) - $signed({2'b00, x1_reg});
        rem_sh = {rem_reg[31:0], prod_reg[bit_reg]};
        rem_sub = rem_sh - {1'b0, mdx_reg};
        sum = neg_reg ? 36'(y1_reg) - $signed({1'b0, quo_reg[34:0]})
                      : 36'(y1_reg) + $signed({1'b0, quo_reg[34:0]});
        case (state_reg)
            wlr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        wlr_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                            seg_next = '0;
                        end
                        wlr_pkg::MODE_APPEND:
                            if (wr_en) count_next = count_reg + CW'(1);
                        wlr_pkg::MODE_QUERY:
                        begin
                            t_next = sample_time;
                            if (count_reg < CW'(2))
                            begin
                                res_next = '0;
                                err_next = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                                state_next = wlr_pkg::ST_CLAMP;
                        end
                        default: ;
                    endcase
                end
            end
            wlr_pkg::ST_CLAMP:
            begin
                if (CW'(seg_reg) > last) seg_next = last[IW-1:0];
                state_next = wlr_pkg::ST_WALK_RD;
            end
            wlr_pkg::ST_WALK_RD:
            begin
                if (CW'(seg_reg) < last)
                    state_next = wlr_pkg::ST_WALK_CHK;
                else
                    state_next = wlr_pkg::ST_RD2;
            end
            wlr_pkg::ST_WALK_CHK:
            begin
                if (rd_t <= t_reg)
                begin
                    seg_next = seg_reg + IW'(1);
                    state_next = wlr_pkg::ST_WALK_RD;
                end
                else
                    state_next = wlr_pkg::ST_RD2;
                rd_addr = seg_reg;
            end
            wlr_pkg::ST_RD2:
            begin
                rd_addr = seg_reg;
                state_next = wlr_pkg::ST_RD3;
            end
            wlr_pkg::ST_RD3:
            begin
                x1_next = rd_t;
                y1_next = rd_v;
                state_next = wlr_pkg::ST_PREP;
            end
            wlr_pkg::ST_PREP:
            begin
                if (t_reg > rd_t)
                    dt = $signed({2'b00, rd_t}) - $signed({2'b00, x1_reg});
                mdy_next = dy[33] ? 32'(-dy) : dy[31:0];
                mdt_next = dt[33] ? 32'(-dt) : dt[31:0];
                mdx_next = dx[33] ? 32'(-dx) : dx[31:0];
                neg_next = (dy[33] ^ dt[33]) ^ dx[33];
                eq_next = (rd_t == x1_reg);
                state_next = wlr_pkg::ST_MUL;
            end
            wlr_pkg::ST_MUL:
            begin
                prod_next = 64'(mdy_reg) * 64'(mdt_reg);
                rem_next = '0;
                quo_next = '0;
                bit_next = 6'd63;
                state_next = eq_reg ? wlr_pkg::ST_FIN : wlr_pkg::ST_DIV;
            end
            wlr_pkg::ST_DIV:
            begin
                if (!rem_sub[32])
                begin
                    rem_next = rem_sub;
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                bit_next = bit_reg - 6'd1;
                if (bit_reg == 6'd0) state_next = wlr_pkg::ST_FIN;
            end
            wlr_pkg::ST_FIN:
            begin
                err_next = 1'b0;
                done_next = 1'b1;
                state_next = wlr_pkg::ST_IDLE;
                if (eq_reg || quo_reg == 64'd0)
                    res_next = y1_reg;
                else if (quo_reg > (64'd1 << 34))
                    res_next = neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                else if (sum > 36'sh0_7fff_ffff)
                    res_next = 32'sh7fff_ffff;
                else if (sum < -36'sh0_8000_0000)
                    res_next = 32'sh8000_0000;
                else
                    res_next = sum[31:0];
            end
            default: state_next = wlr_pkg::ST_IDLE;
        endcase
    end

    assign busy = (state_reg != wlr_pkg::ST_IDLE);
    assign done = done_reg;
    assign interpolated_value = res_reg;
    assign error_flag = err_reg;

    `ASSERT_IMPL(a_seg_bound, clk, rst_n,
        (state_reg == wlr_pkg::ST_RD2) |-> (CW'(seg_reg) <= last), "segment past table")
    `ASSERT_IMPL(a_fin_done, clk, rst_n, (state_reg == wlr_pkg::ST_FIN) |=> done_reg,
        "finished query gave no result")
    `ASSERT_NEVER(a_err_value, clk, rst_n, done_reg && err_reg && (res_reg != 32'sd0),
        "error result not zero")
    `ASSERT_NEVER(a_count_max, clk, rst_n, count_reg > CW'(wlr_pkg::MAX_POINTS),
        "count over table size")
endmodule
